>>> hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the block allocator.
// Depends on nothing; full checks in simulation, empty bodies for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at every clock edge outside reset.
`define BBA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never occurs outside reset.
`define BBA_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BBA_ASSERT(label, clk, rst_n, prop, msg)
`define BBA_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

>>> hw/rtl/bba_pkg.sv
// Package of the bitmap block allocator: payload structs, mode codes and defaults.
// Used by bba_id_split and bitmap_block_allocator; depends on nothing.
package bba_pkg;

	localparam int ID_W = 16;

	localparam int NUM_BLOCKS_DEF      = 65536;
	localparam int RESERVED_BLOCKS_DEF = 16;
	localparam int MAP_WORD_BITS_DEF   = 64;

	// largest block number that granted_block can carry, plus one
	localparam int ID_SPAN = 65536;

	localparam logic [1:0] MODE_ALLOC   = 2'd0;
	localparam logic [1:0] MODE_REQUEST = 2'd1;
	localparam logic [1:0] MODE_RELEASE = 2'd2;

	typedef struct packed {
		logic [1:0]      mode;
		logic [ID_W-1:0] blk_num;
	} bba_req_t;

	typedef struct packed {
		logic            ok;
		logic [ID_W-1:0] granted_block;
	} bba_rsp_t;

endpackage

>>> hw/rtl/bitmap_block_allocator.sv
// Top level of the first-fit bitmap block allocator: sequencer and bitmap memory.
// Uses bba_pkg, bba_id_split and assert_macros.svh.
//
// Usage: present a request on request and raise start; it is taken at a clock
// edge where start is high and busy is low. Each request gives one result on
// result, marked by done for exactly one cycle; the receiver cannot stall it.
// The bitmap sits in a one-port-read, one-port-write memory of
// ceil(NUM_BLOCKS / MAP_WORD_BITS) words (1024 by default).
// After reset a clearing pass writes every map word once, one per cycle,
// marking the reserved low blocks in use; busy stays high until the pass
// has written the last word.
// Allocate reads one map word per cycle from word 0 up and grants the lowest
// clear bit; a full map fails once the scan has passed the word that holds
// block min(NUM_BLOCKS, 65536) - 1.
// Request and release go through the word/bit split (ST_SPLIT1, ST_SPLIT2),
// a memory read (ST_LOOKUP) and a read-modify-write (ST_MODIFY). Mode 3
// answers in the next cycle. busy drops as the result goes out, so the next
// request may be taken in the cycle that done is high.
`include "assert_macros.svh"

module bitmap_block_allocator #(
	parameter int NUM_BLOCKS      = bba_pkg::NUM_BLOCKS_DEF,
	parameter int RESERVED_BLOCKS = bba_pkg::RESERVED_BLOCKS_DEF,
	parameter int MAP_WORD_BITS   = bba_pkg::MAP_WORD_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  bba_pkg::bba_req_t request,
	output logic              done,
	output bba_pkg::bba_rsp_t result
);

	localparam int W          = MAP_WORD_BITS;
	localparam int MAP_DEPTH  = (NUM_BLOCKS + W - 1) / W;
	localparam int ADDR_W     = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
	localparam int BIT_W      = $clog2(W);
	localparam int LIMIT      = (NUM_BLOCKS > bba_pkg::ID_SPAN) ? bba_pkg::ID_SPAN : NUM_BLOCKS;
	localparam int SCAN_DEPTH = (LIMIT + W - 1) / W;
	localparam int LAST_BITS  = LIMIT - (SCAN_DEPTH - 1) * W;
	localparam int RES_EFF    = (RESERVED_BLOCKS > NUM_BLOCKS) ? NUM_BLOCKS : RESERVED_BLOCKS;
	localparam int RES_FULL   = RES_EFF / W;
	localparam int RES_PART   = RES_EFF % W;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_DEPTH - 1);
	localparam logic [ADDR_W-1:0] SCAN_LAST = ADDR_W'(SCAN_DEPTH - 1);
	localparam logic [W-1:0]      LAST_MASK = {W{1'b1}} >> (W - LAST_BITS);
	localparam logic [W-1:0]      PART_MASK = ~({W{1'b1}} << RES_PART);

	typedef enum logic [6:0] {
		ST_INIT   = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_SCAN   = 7'b0000100,
		ST_SPLIT1 = 7'b0001000,
		ST_SPLIT2 = 7'b0010000,
		ST_LOOKUP = 7'b0100000,
		ST_MODIFY = 7'b1000000
	} state_t;

	state_t                    state_q, state_d;
	logic [ADDR_W-1:0]         init_addr_q;
	logic [ADDR_W-1:0]         cur_q, cur_d;
	logic [bba_pkg::ID_W-1:0]  base_q, base_d;
	logic [1:0]                mode_q;
	logic [bba_pkg::ID_W-1:0]  id_q;
	logic                      done_q, done_d;
	logic                      ok_q, ok_d;
	logic [bba_pkg::ID_W-1:0]  granted_q, granted_d;

	logic [W-1:0]      map_mem [MAP_DEPTH];
	logic [W-1:0]      rdata_q;
	logic              rd_en, wr_en;
	logic [ADDR_W-1:0] raddr, waddr;
	logic [W-1:0]      wdata;

	logic [ADDR_W-1:0] word_s2;
	logic [BIT_W-1:0]  bit_s2;
	logic [W-1:0]      bit_mask;
	logic [W-1:0]      free_bits;
	logic [BIT_W-1:0]  first_free;
	logic [W-1:0]      init_word;
	logic              in_range;

	bba_id_split #(
		.WORD_BITS (W),
		.ADDR_W    (ADDR_W),
		.BIT_W     (BIT_W)
	) u_split (
		.clk     (clk),
		.id      (id_q),
		.word_s2 (word_s2),
		.bit_s2  (bit_s2)
	);

	// bitmap memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_q <= map_mem[raddr];
		end
	end

	assign bit_mask  = W'(1) << bit_s2;
	assign free_bits = ~rdata_q & ((cur_q == SCAN_LAST) ? LAST_MASK : {W{1'b1}});
	assign in_range  = (32'(id_q) >= RESERVED_BLOCKS) && (32'(id_q) < NUM_BLOCKS);

	always_comb begin
		if (32'(init_addr_q) < RES_FULL) begin
			init_word = {W{1'b1}};
		end else if (32'(init_addr_q) == RES_FULL) begin
			init_word = PART_MASK;
		end else begin
			init_word = '0;
		end
	end

	// lowest clear bit of the word under scan
	always_comb begin
		first_free = '0;
		for (int i = W - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				first_free = BIT_W'(i);
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		cur_d     = cur_q;
		base_d    = base_q;
		done_d    = 1'b0;
		ok_d      = 1'b0;
		granted_d = '0;
		rd_en     = 1'b0;
		raddr     = cur_q;
		wr_en     = 1'b0;
		waddr     = cur_q;
		wdata     = rdata_q;
		unique case (state_q)
			ST_INIT: begin
				wr_en = 1'b1;
				waddr = init_addr_q;
				wdata = init_word;
				if (init_addr_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					unique case (request.mode) inside
						bba_pkg::MODE_ALLOC: begin
							rd_en   = 1'b1;
							raddr   = '0;
							cur_d   = '0;
							base_d  = '0;
							state_d = ST_SCAN;
						end
						bba_pkg::MODE_REQUEST, bba_pkg::MODE_RELEASE: begin
							state_d = ST_SPLIT1;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (|free_bits) begin
					wr_en     = 1'b1;
					wdata     = rdata_q | (W'(1) << first_free);
					done_d    = 1'b1;
					ok_d      = 1'b1;
					granted_d = base_q + bba_pkg::ID_W'(first_free);
					state_d   = ST_IDLE;
				end else if (cur_q == SCAN_LAST) begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					// advance to the next map word
					rd_en  = 1'b1;
					raddr  = cur_q + ADDR_W'(1);
					cur_d  = cur_q + ADDR_W'(1);
					base_d = base_q + bba_pkg::ID_W'(W);
				end
			end
			ST_SPLIT1: begin
				state_d = ST_SPLIT2;
			end
			ST_SPLIT2: begin
				state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				if (in_range) begin
					rd_en   = 1'b1;
					raddr   = word_s2;
					state_d = ST_MODIFY;
				end else begin
					done_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_MODIFY: begin
				waddr   = word_s2;
				done_d  = 1'b1;
				state_d = ST_IDLE;
				if (mode_q == bba_pkg::MODE_REQUEST) begin
					if ((rdata_q & bit_mask) == '0) begin
						wr_en = 1'b1;
						wdata = rdata_q | bit_mask;
						ok_d  = 1'b1;
					end
				end else begin
					wr_en = 1'b1;
					wdata = rdata_q & ~bit_mask;
					ok_d  = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			init_addr_q <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (state_q == ST_INIT) begin
				init_addr_q <= init_addr_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q     <= cur_d;
		base_q    <= base_d;
		ok_q      <= ok_d;
		granted_q <= granted_d;
		if (state_q == ST_IDLE && start) begin
			mode_q <= request.mode;
			id_q   <= request.blk_num;
		end
	end

	assign busy                 = (state_q != ST_IDLE);
	assign done                 = done_q;
	assign result.ok            = ok_q;
	assign result.granted_block = granted_q;

	`BBA_ASSERT(a_fail_no_block, clk, arst_n, done_q && !ok_q |-> granted_q == '0, "block on fail")
	`BBA_ASSERT(a_grant_is_ok, clk, arst_n, done_q && granted_q != '0 |-> ok_q, "grant without ok")
	`BBA_ASSERT(a_scan_bound, clk, arst_n, state_q == ST_SCAN |-> cur_q <= SCAN_LAST, "scan overrun")
	`BBA_NEVER(a_no_result_in_init, clk, arst_n, done_q && $past(state_q) == ST_INIT, "done in init")

endmodule

>>> hw/rtl/bba_id_split.sv
// Two-stage split of a block number into map word index and bit offset.
// Uses bba_pkg; divides by the word width through a reciprocal multiply.
module bba_id_split #(
	parameter int WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF,
	parameter int ADDR_W    = 10,
	parameter int BIT_W     = 6
) (
	input  logic                      clk,
	input  logic [bba_pkg::ID_W-1:0]  id,
	output logic [ADDR_W-1:0]         word_s2,
	output logic [BIT_W-1:0]          bit_s2
);

	localparam int L_W   = $clog2(WORD_BITS);
	localparam int SHIFT = bba_pkg::ID_W + L_W;
	localparam int M_W   = bba_pkg::ID_W + 2;
	localparam int P_W   = bba_pkg::ID_W + M_W;
	// ceiling reciprocal: exact quotient for every 16-bit id
	localparam logic [M_W-1:0] RECIP =
		M_W'(((64'd1 << SHIFT) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS));

	logic [P_W-1:0]               prod;
	logic [bba_pkg::ID_W-1:0]     q_s1;
	logic [bba_pkg::ID_W-1:0]     id_s1;
	logic [bba_pkg::ID_W-1:0]     back;

	assign prod = P_W'(id) * P_W'(RECIP);
	assign back = q_s1 * bba_pkg::ID_W'(WORD_BITS);

	always_ff @(posedge clk) begin
		q_s1    <= bba_pkg::ID_W'(prod >> SHIFT);
		id_s1   <= id;
		word_s2 <= ADDR_W'(q_s1);
		bit_s2  <= BIT_W'(id_s1 - back);
	end

endmodule
